>>> rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg - text console cursor engine package
// Screen geometry, command codes, item types and address helpers.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // Fixed field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam logic [ATTR_W-1:0] COLOR_RESET = 8'h07;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_word;
    } out_item_t;

    // Linear cell index of (row, col)
    function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r,
                                                    logic [COL_W-1:0] c);
        return ADDR_W'(int'(r) * COLUMNS + int'(c));
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(logic [COL_W-1:0] c);
        return (c > COL_MAX) ? COL_MAX : c;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_row(logic [ROW_W-1:0] r);
        return (r > ROW_MAX) ? ROW_MAX : r;
    endfunction

endpackage

>>> rtl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine - text-mode console with cursor
// Cell store, cursor and a small sequencer for print, scroll, clear and read.
// ----------------------------------------------------------------------------
// One item at a time. Put character (print, newline off the last row,
// backspace) and set cursor go through the emit state into the output register;
// read cell first waits in the read state on the registered RAM read. Clear
// screen writes all CELL_COUNT cells and a newline on the last row scrolls
// the store up one row and blanks the bottom row, one cell per cycle, through
// the single RAM write port. After reset every cell is swept to zero, with
// s_ready low; cfg writes are taken at any time. The result sits in an output
// register, so the next item is accepted while a result still waits on m_.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration: text_color
    input  logic                        cfg_wr_en,
    input  logic [tcce_pkg::ATTR_W-1:0] cfg_wr_data,
    // command items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tcce_pkg::in_item_t          s_data,
    // result items
    output logic                        m_valid,
    input  logic                        m_ready,
    output tcce_pkg::out_item_t         m_data
);

    import tcce_pkg::*;

    localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(COLUMNS * (ROWS - 1));
    localparam logic [ADDR_W-1:0] FILL_LAST   = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,    // waiting on RAM read data
        ST_SCROLL,  // moving rows up by one
        ST_FILL,    // writing fill_data from ptr to the end of the store
        ST_EMIT     // result waits for the output register
    } state_t;

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [ATTR_W-1:0]   color_reg;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [CELL_W-1:0]   fill_data_reg, fill_data_next;
    logic                fill_emit_reg, fill_emit_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    // RAM port signals
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    logic [ADDR_W-1:0]   cur_lin;

    assign cur_lin = cell_addr(cur_row_reg, cur_col_reg);
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        ptr_next       = ptr_reg;
        fill_data_next = fill_data_reg;
        fill_emit_next = fill_emit_reg;
        cell_next      = cell_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = ptr_reg;
        ram_wdata = fill_data_reg;
        // Default read address serves the read-cell command
        ram_raddr = cell_addr(clamp_row(s_data.row), clamp_col(s_data.col));

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cell_next = '0;
                    unique case (s_data.command)
                        CMD_PUT: begin
                            if (s_data.char_code == CODE_NEWLINE) begin
                                cur_col_next = '0;
                                if (cur_row_reg >= ROW_MAX) begin
                                    // last row: scroll the store up one row
                                    cur_row_next = ROW_MAX;
                                    ptr_next     = '0;
                                    state_next   = ST_SCROLL;
                                end else begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                    state_next   = ST_EMIT;
                                end
                            end else if (s_data.char_code == CODE_BACKSPACE) begin
                                // at the origin nothing changes
                                if (cur_col_reg != '0 || cur_row_reg != '0) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = cur_lin - 1'b1;
                                    ram_wdata = {color_reg, CODE_NUL};
                                    if (cur_col_reg != '0) begin
                                        cur_col_next = cur_col_reg - 1'b1;
                                    end else begin
                                        cur_col_next = COL_MAX;
                                        cur_row_next = cur_row_reg - 1'b1;
                                    end
                                end
                                state_next = ST_EMIT;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = cur_lin;
                                ram_wdata = {color_reg, s_data.char_code};
                                if (cur_col_reg >= COL_MAX) begin
                                    cur_col_next = '0;
                                    cur_row_next = (cur_row_reg >= ROW_MAX) ? '0
                                                   : cur_row_reg + 1'b1;
                                end else begin
                                    cur_col_next = cur_col_reg + 1'b1;
                                end
                                state_next = ST_EMIT;
                            end
                        end
                        CMD_SET: begin
                            cur_col_next = clamp_col(s_data.col);
                            cur_row_next = clamp_row(s_data.row);
                            state_next   = ST_EMIT;
                        end
                        CMD_CLEAR: begin
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                            ptr_next       = '0;
                            fill_data_next = {color_reg, CODE_SPACE};
                            fill_emit_next = 1'b1;
                            state_next     = ST_FILL;
                        end
                        CMD_READ: begin
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                cell_next  = ram_rdata;
                state_next = ST_EMIT;
            end
            ST_SCROLL: begin
                // read ptr+COLUMNS, write what was read last cycle to ptr-1
                if (ptr_reg != SCROLL_LAST) begin
                    ram_raddr = ptr_reg + ROW_STRIDE;
                end
                if (ptr_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (ptr_reg == SCROLL_LAST) begin
                    fill_data_next = {color_reg, CODE_NUL};
                    fill_emit_next = 1'b1;
                    state_next     = ST_FILL;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_FILL: begin
                ram_we = 1'b1;
                if (ptr_reg == FILL_LAST) begin
                    state_next = fill_emit_reg ? ST_EMIT : ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.cursor_col      = cur_col_reg;
                    m_data_next.cursor_row      = cur_row_reg;
                    m_data_next.cursor_position = POS_W'(cur_lin);
                    m_data_next.cell_word       = cell_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // reset sweep writes zero into every cell
            state_reg     <= ST_FILL;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            color_reg     <= COLOR_RESET;
            ptr_reg       <= '0;
            fill_data_reg <= '0;
            fill_emit_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            ptr_reg       <= ptr_next;
            fill_data_reg <= fill_data_next;
            fill_emit_reg <= fill_emit_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                color_reg <= cfg_wr_data;
            end
        end
        cell_reg   <= cell_next;
        m_data_reg <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    // one item at a time: busy in the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a second item back to back");

    // cursor stays on the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_col_reg <= COL_MAX && cur_row_reg <= ROW_MAX)
        else $error("cursor off screen");

    // every cell write lands inside the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ram_waddr <= FILL_LAST)
        else $error("cell write out of range");

    // a result is only loaded from the emit state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised outside emit");
`endif

endmodule

>>> rtl/tcce_ram.sv
// ----------------------------------------------------------------------------
// tcce_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> test/text_console_cursor_engine_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_tb - self-checking bench for the console engine
// Drives command items with random idling and back-pressure. A shadow copy of
// the screen, cursor and attribute predicts every cursor report, which is
// checked field by field against the result stream, oldest first.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_tb;

    import tcce_pkg::*;

    localparam int LONG_HOLD      = 400;    // receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no item moving
    localparam int PHASE_ITEMS    = 305;
    localparam int PHASES         = 5;
    localparam int REPORT_LIMIT   = 10;

    // ------------------------------------------------------------------------
    // Shadow of the console: predicts one cursor report per command item and
    // checks the reports that come back in order.
    // ------------------------------------------------------------------------
    class console_scoreboard;
        logic [CELL_W-1:0] screen [CELL_COUNT];
        logic [COL_W-1:0]  pos_col;
        logic [ROW_W-1:0]  pos_row;
        logic [ATTR_W-1:0] attr;
        out_item_t         pending_reports [$];
        int                errors;

        function new();
            foreach (screen[i]) screen[i] = '0;
            pos_col = '0;
            pos_row = '0;
            attr    = COLOR_RESET;
            errors  = 0;
        endfunction

        function void set_color(logic [ATTR_W-1:0] value);
            attr = value;
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction

        // Apply one accepted command to the shadow and queue its report.
        function void note_command(in_item_t it);
            out_item_t        rep;
            int               addr;
            int               i;
            logic [COL_W-1:0] c;
            logic [ROW_W-1:0] r;
            rep = '0;
            case (it.command)
                CMD_PUT: begin
                    if (it.char_code == CODE_NEWLINE) begin
                        if (pos_row >= ROW_MAX) begin
                            // scroll up one row, blank the bottom row
                            for (i = 0; i < COLUMNS * (ROWS - 1); i++)
                                screen[i] = screen[i + COLUMNS];
                            for (i = COLUMNS * (ROWS - 1); i < CELL_COUNT; i++)
                                screen[i] = {attr, CODE_NUL};
                            pos_row = ROW_MAX;
                        end else begin
                            pos_row = pos_row + 1'b1;
                        end
                        pos_col = '0;
                    end else if (it.char_code == CODE_BACKSPACE) begin
                        // nothing to erase at the origin
                        if (pos_col != '0 || pos_row != '0) begin
                            addr = int'(pos_row) * COLUMNS + int'(pos_col) - 1;
                            screen[addr] = {attr, CODE_NUL};
                            if (pos_col != '0) begin
                                pos_col = pos_col - 1'b1;
                            end else begin
                                pos_col = COL_MAX;
                                pos_row = pos_row - 1'b1;
                            end
                        end
                    end else begin
                        addr = int'(pos_row) * COLUMNS + int'(pos_col);
                        screen[addr] = {attr, it.char_code};
                        // wrap off the last row goes to the top, no scroll
                        if (pos_col == COL_MAX) begin
                            pos_col = '0;
                            pos_row = (pos_row == ROW_MAX) ? '0 : pos_row + 1'b1;
                        end else begin
                            pos_col = pos_col + 1'b1;
                        end
                    end
                end
                CMD_SET: begin
                    pos_col = (it.col > COL_MAX) ? COL_MAX : it.col;
                    pos_row = (it.row > ROW_MAX) ? ROW_MAX : it.row;
                end
                CMD_CLEAR: begin
                    for (i = 0; i < CELL_COUNT; i++) screen[i] = {attr, CODE_SPACE};
                    pos_col = '0;
                    pos_row = '0;
                end
                default: begin
                    c = (it.col > COL_MAX) ? COL_MAX : it.col;
                    r = (it.row > ROW_MAX) ? ROW_MAX : it.row;
                    rep.cell_word = screen[int'(r) * COLUMNS + int'(c)];
                end
            endcase
            rep.cursor_col      = pos_col;
            rep.cursor_row      = pos_row;
            rep.cursor_position = POS_W'(int'(pos_row) * COLUMNS + int'(pos_col));
            pending_reports.push_back(rep);
        endfunction

        function void check_report(out_item_t got);
            out_item_t want;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("MISMATCH: unexpected report col=%0d row=%0d pos=%0d cell=%h",
                             got.cursor_col, got.cursor_row, got.cursor_position,
                             got.cell_word);
                return;
            end
            want = pending_reports.pop_front();
            if (got.cursor_col !== want.cursor_col ||
                got.cursor_row !== want.cursor_row ||
                got.cursor_position !== want.cursor_position ||
                got.cell_word !== want.cell_word) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("MISMATCH: col %0d/%0d row %0d/%0d pos %0d/%0d cell %h/%h",
                             want.cursor_col, got.cursor_col,
                             want.cursor_row, got.cursor_row,
                             want.cursor_position, got.cursor_position,
                             want.cell_word, got.cell_word);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [ATTR_W-1:0] cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    in_item_t          s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    out_item_t         m_data;

    console_scoreboard sb = new();

    bit hold_request = 1'b0;  // asks the receiver for one long hold-off
    bit quiet        = 1'b0;  // no idling on either side
    int rx_hold      = 0;
    int rx_calm      = 0;
    int idle_cycles  = 0;

    text_console_cursor_engine i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #4 aclk = ~aclk;

    // Receiver: random stall bursts, calm stretches, and one long hold-off
    // so the output register fills and the block stops taking items.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            rx_hold = LONG_HOLD;
        end
        if (rx_hold > 0 && !quiet) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else if (quiet || rx_calm > 0) begin
            m_ready <= 1'b1;
            if (rx_calm > 0) rx_calm--;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    m_ready <= 1'b0;
                    rx_hold = $urandom_range(0, 8);
                end
                1: begin
                    m_ready <= 1'b1;
                    rx_calm = $urandom_range(20, 120);
                end
                default: m_ready <= 1'b1;
            endcase
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_report(m_data);
    end

    // Watchdog: clears, scrolls and the post-reset sweep hold the input while they
    // walk the store, so the limit is set well above those sweeps.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic in_item_t cmd_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                          logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
        in_item_t it;
        it.command   = cmd;
        it.char_code = ch;
        it.col       = c;
        it.row       = r;
        return it;
    endfunction

    task automatic idle_sender(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Offer one item, hold it until taken, then maybe idle for a burst.
    task automatic put_item(input in_item_t it);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_command(it);
        if (!quiet && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 9));
    endtask

    // Stop offering and wait until every report is back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_color(input logic [ATTR_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_color(value);
    endtask

    function automatic logic [COL_W-1:0] pick_col();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return COL_W'($urandom_range(0, COLUMNS - 1));
            4, 5, 6:    return COL_W'($urandom_range(COLUMNS - 8, COLUMNS - 1));
            default:    return COL_W'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return ROW_MAX;
            4, 5:       return ROW_W'($urandom_range(ROWS - 5, 31));
            default:    return ROW_W'($urandom_range(0, ROWS - 1));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return CODE_NEWLINE;
        if (r < 18) return CODE_BACKSPACE;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Random traffic in segments: mostly text runs from a placed cursor and
    // reads near it, the rest noise and an occasional clear.
    task automatic run_traffic(input int count);
        int               sent;
        int               len;
        int               k;
        int               c;
        int               r;
        logic [CMD_W-1:0] cmd;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 31))
                0: begin
                    put_item(cmd_item(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                                      COL_W'($urandom_range(0, 127)),
                                      ROW_W'($urandom_range(0, 31))));
                    sent++;
                end
                1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15: begin
                    put_item(cmd_item(CMD_SET, CHAR_W'($urandom_range(0, 255)),
                                      pick_col(), pick_row()));
                    len = $urandom_range(4, 30);
                    for (k = 0; k < len; k++)
                        put_item(cmd_item(CMD_PUT, pick_char(),
                                          COL_W'($urandom_range(0, 127)),
                                          ROW_W'($urandom_range(0, 31))));
                    sent += len + 1;
                end
                16, 17, 18, 19, 20, 21, 22, 23: begin
                    len = $urandom_range(2, 8);
                    for (k = 0; k < len; k++) begin
                        if ($urandom_range(0, 1) == 0) begin
                            // just behind the cursor, where text was written
                            c = int'(sb.pos_col) - int'($urandom_range(0, 6));
                            r = int'(sb.pos_row) - int'($urandom_range(0, 1));
                            if (c < 0) c = 0;
                            if (r < 0) r = 0;
                        end else begin
                            c = $urandom_range(0, 127);
                            r = $urandom_range(0, 31);
                        end
                        put_item(cmd_item(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                                          COL_W'(c), ROW_W'(r)));
                    end
                    sent += len;
                end
                default: begin
                    len = $urandom_range(1, 6);
                    for (k = 0; k < len; k++) begin
                        case ($urandom_range(0, 2))
                            0:       cmd = CMD_PUT;
                            1:       cmd = CMD_SET;
                            default: cmd = CMD_READ;
                        endcase
                        put_item(cmd_item(cmd, CHAR_W'($urandom_range(0, 255)),
                                          COL_W'($urandom_range(0, 127)),
                                          ROW_W'($urandom_range(0, 31))));
                    end
                    sent += len;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int p;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset attribute
        put_item(cmd_item(CMD_READ, CODE_NUL, 7'd0, 5'd0));          // store cleared
        put_item(cmd_item(CMD_READ, 8'hFF, 7'h7F, 5'h1F));           // clamped read
        put_item(cmd_item(CMD_PUT, CODE_BACKSPACE, 7'd0, 5'd0));     // origin: no-op
        put_item(cmd_item(CMD_PUT, 8'h41, 7'd0, 5'd0));
        put_item(cmd_item(CMD_PUT, CODE_BACKSPACE, 7'd0, 5'd0));
        put_item(cmd_item(CMD_READ, CODE_NUL, 7'd0, 5'd0));
        put_item(cmd_item(CMD_SET, CODE_NUL, COL_MAX, 5'd0));
        put_item(cmd_item(CMD_PUT, 8'hFF, 7'd0, 5'd0));              // wrap to next row
        put_item(cmd_item(CMD_PUT, CODE_BACKSPACE, 7'd0, 5'd0));     // back to row above
        put_item(cmd_item(CMD_READ, CODE_NUL, COL_MAX, 5'd0));
        put_item(cmd_item(CMD_PUT, CODE_NEWLINE, 7'd0, 5'd0));       // newline, no scroll
        put_item(cmd_item(CMD_SET, CODE_NUL, 7'h7F, 5'h1F));         // clamped set
        put_item(cmd_item(CMD_PUT, CODE_NUL, 7'd0, 5'd0));           // wrap to top
        put_item(cmd_item(CMD_SET, CODE_NUL, 7'd5, ROW_MAX));
        put_item(cmd_item(CMD_PUT, 8'h78, 7'd0, 5'd0));
        put_item(cmd_item(CMD_PUT, CODE_NEWLINE, 7'd0, 5'd0));       // scroll
        put_item(cmd_item(CMD_READ, CODE_NUL, 7'd5, ROW_MAX - 1'b1));
        put_item(cmd_item(CMD_READ, CODE_NUL, 7'd0, ROW_MAX));
        put_item(cmd_item(CMD_CLEAR, 8'hFF, 7'h7F, 5'h1F));
        put_item(cmd_item(CMD_READ, CODE_NUL, 7'd40, 5'd12));
        put_item(cmd_item(CMD_SET, 8'hFF, 7'd0, 5'd0));              // char ignored
        put_item(cmd_item(CMD_PUT, 8'h7E, 7'h7F, 5'h1F));            // col/row ignored
        put_item(cmd_item(CMD_READ, CODE_NUL, 7'd0, 5'd0));
        drain();

        // Random phases, each under its own attribute; the last runs flat out
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       write_color(8'hFF);
                1:       write_color(8'h00);
                default: write_color(ATTR_W'($urandom_range(0, 255)));
            endcase
            if (p == 1) hold_request = 1'b1;
            if (p == PHASES - 1) quiet = 1'b1;
            run_traffic(PHASE_ITEMS);
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/text_console_cursor_engine.sv
test/text_console_cursor_engine_tb.sv
